// ===== hdl/dmer_pkg.sv =====
// dmer_pkg: shared widths and control/status structs for the mirrored edge rasteriser
// used by dmer_ctrl, dmer_dp and dda_mirrored_edge_rasterizer_unit
package dmer_pkg;

  // fixed field widths
  localparam int COORD_W  = 6;
  localparam int ORIGIN_W = 10;
  localparam int LIFT_W   = 8;
  localparam int OUT_W    = 12;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch a new item and set up the division
    logic div_step;  // one restoring division step on both axes
    logic emit;      // load the result register and advance the point
  } dmer_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_point;  // current point is the end of the segment
  } dmer_stat_t;

endpackage

// ===== hdl/dmer_ctrl.sv =====
// dmer_ctrl: sequencer for accept, iterative division and point emission
// depends on dmer_pkg
module dmer_ctrl import dmer_pkg::*; #(
  parameter int DIV_CYC = 22
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dmer_cmd_t  cmd,
  input  dmer_stat_t stat
);

  localparam int CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // commands decoded from state and handshakes
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.div_step = (state_r == ST_DIV);
    cmd.emit     = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      ST_IDLE: begin
        div_cnt_nxt = '0;
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == CNT_W'(DIV_CYC - 1)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && stat.last_point) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid: set on emit, cleared when taken
  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DIV))
    else $error("accepted item did not start the division");

  a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= CNT_W'(DIV_CYC - 1)))
    else $error("division counter overran");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.last_point) |=> (state_r == ST_IDLE))
    else $error("controller busy after the final point");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result valid raised without an emit");

endmodule

// ===== hdl/dmer_dp.sv =====
// dmer_dp: saturation, serial increment division, point accumulators and result register
// depends on dmer_pkg
module dmer_dp import dmer_pkg::*; #(
  parameter int MAX_REACH = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  dmer_cmd_t                  cmd,
  output dmer_stat_t                 stat,
  input  logic signed [COORD_W-1:0]  in_start_x,
  input  logic signed [COORD_W-1:0]  in_start_y,
  input  logic signed [COORD_W-1:0]  in_end_x,
  input  logic signed [COORD_W-1:0]  in_end_y,
  input  logic        [ORIGIN_W-1:0] in_origin_x,
  input  logic        [ORIGIN_W-1:0] in_origin_y,
  input  logic        [LIFT_W-1:0]   in_lift,
  output logic signed [OUT_W-1:0]    out_near_x,
  output logic signed [OUT_W-1:0]    out_near_y,
  output logic signed [OUT_W-1:0]    out_mirror_x,
  output logic signed [OUT_W-1:0]    out_mirror_y,
  output logic signed [OUT_W-1:0]    out_near_top_y,
  output logic signed [OUT_W-1:0]    out_mirror_top_y,
  output logic                       out_last
);

  localparam int MAG_W = $clog2(2 * MAX_REACH + 1);
  localparam int DIV_W = MAG_W + FRAC_BITS;
  localparam int POS_W = MAG_W + FRAC_BITS;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int SUM_W = OUT_W + FRAC_BITS;
  localparam int D_W   = COORD_W + 1;
  localparam logic signed [COORD_W-1:0] REACH_P = COORD_W'(MAX_REACH);
  localparam logic signed [COORD_W-1:0] REACH_N = -REACH_P;

  // clamp a coordinate to the reach
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] r;
    r = c;
    if (c > REACH_P) r = REACH_P;
    if (c < REACH_N) r = REACH_N;
    return r;
  endfunction

  // fixed point to integer, rounding toward zero
  function automatic logic signed [OUT_W-1:0] trunc_fix(input logic signed [SUM_W-1:0] v);
    logic [OUT_W-1:0] ip;
    logic             up;
    ip = v[SUM_W-1:FRAC_BITS];
    up = v[SUM_W-1] && (|v[FRAC_BITS-1:0]);
    return $signed(ip + OUT_W'(up));
  endfunction

  // setup arithmetic on the incoming item
  logic signed [COORD_W-1:0] sx, sy, ex, ey;
  logic signed [D_W-1:0]     dx, dy;
  logic        [D_W-1:0]     adx_w, ady_w;
  logic        [MAG_W-1:0]   adx, ady, steps;

  always_comb begin
    sx    = sat_coord(in_start_x);
    sy    = sat_coord(in_start_y);
    ex    = sat_coord(in_end_x);
    ey    = sat_coord(in_end_y);
    dx    = D_W'(ex) - D_W'(sx);
    dy    = D_W'(ey) - D_W'(sy);
    adx_w = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ady_w = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    adx   = adx_w[MAG_W-1:0];
    ady   = ady_w[MAG_W-1:0];
    steps = (adx > ady) ? adx : ady;
  end

  // item registers
  logic        [MAG_W-1:0]  steps_r, left_r;
  logic                     neg_x_r, neg_y_r;
  logic signed [OUT_W-1:0]  org_x_r, org_y_r, org_top_r;
  logic        [DIV_W-1:0]  num_x_r, num_y_r;
  logic        [MAG_W-1:0]  rem_x_r, rem_y_r;
  logic        [Q_W-1:0]    q_x_r, q_y_r;
  logic signed [POS_W-1:0]  px_r, py_r;

  // one restoring division step per axis, shared divisor
  logic [MAG_W:0]   rsh_x, rsh_y;
  logic             qb_x, qb_y;
  logic [MAG_W-1:0] rem_x_nxt, rem_y_nxt;

  always_comb begin
    rsh_x     = {rem_x_r, num_x_r[DIV_W-1]};
    rsh_y     = {rem_y_r, num_y_r[DIV_W-1]};
    qb_x      = (rsh_x >= {1'b0, steps_r});
    qb_y      = (rsh_y >= {1'b0, steps_r});
    rem_x_nxt = qb_x ? MAG_W'(rsh_x - {1'b0, steps_r}) : rsh_x[MAG_W-1:0];
    rem_y_nxt = qb_y ? MAG_W'(rsh_y - {1'b0, steps_r}) : rsh_y[MAG_W-1:0];
  end

  // signed increments, zero for a single point
  logic signed [POS_W-1:0] inc_x, inc_y;

  always_comb begin
    inc_x = '0;
    inc_y = '0;
    if (steps_r != '0) begin
      inc_x = neg_x_r ? -POS_W'(q_x_r) : POS_W'(q_x_r);
      inc_y = neg_y_r ? -POS_W'(q_y_r) : POS_W'(q_y_r);
    end
  end

  // pixel sums for the current point
  logic signed [SUM_W-1:0] pxe, pye, fox, foy, ftop;
  logic signed [OUT_W-1:0] near_x_nxt, near_y_nxt, mirror_x_nxt, mirror_y_nxt;
  logic signed [OUT_W-1:0] near_top_nxt, mirror_top_nxt;

  always_comb begin
    pxe            = SUM_W'(px_r);
    pye            = SUM_W'(py_r);
    fox            = {org_x_r, {FRAC_BITS{1'b0}}};
    foy            = {org_y_r, {FRAC_BITS{1'b0}}};
    ftop           = {org_top_r, {FRAC_BITS{1'b0}}};
    near_x_nxt     = trunc_fix(fox + pxe);
    near_y_nxt     = trunc_fix(foy + pye);
    mirror_x_nxt   = trunc_fix(fox - pxe);
    mirror_y_nxt   = trunc_fix(foy - pye);
    near_top_nxt   = trunc_fix(ftop + pye);
    mirror_top_nxt = trunc_fix(ftop - pye);
  end

  assign stat.last_point = (left_r == '0);

  // item setup, division and stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps_r   <= steps;
      left_r    <= steps;
      neg_x_r   <= dx[D_W-1];
      neg_y_r   <= dy[D_W-1];
      org_x_r   <= $signed({2'b00, in_origin_x});
      org_y_r   <= $signed({2'b00, in_origin_y});
      org_top_r <= $signed({2'b00, in_origin_y}) - $signed({4'b0000, in_lift});
      num_x_r   <= {adx, {FRAC_BITS{1'b0}}};
      num_y_r   <= {ady, {FRAC_BITS{1'b0}}};
      rem_x_r   <= '0;
      rem_y_r   <= '0;
      q_x_r     <= '0;
      q_y_r     <= '0;
      px_r      <= $signed({sx[MAG_W-1:0], {FRAC_BITS{1'b0}}});
      py_r      <= $signed({sy[MAG_W-1:0], {FRAC_BITS{1'b0}}});
    end else if (cmd.div_step) begin
      num_x_r <= {num_x_r[DIV_W-2:0], 1'b0};
      num_y_r <= {num_y_r[DIV_W-2:0], 1'b0};
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= {q_x_r[Q_W-2:0], qb_x};
      q_y_r   <= {q_y_r[Q_W-2:0], qb_y};
    end else if (cmd.emit) begin
      px_r   <= px_r + inc_x;
      py_r   <= py_r + inc_y;
      left_r <= left_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_near_x       <= near_x_nxt;
      out_near_y       <= near_y_nxt;
      out_mirror_x     <= mirror_x_nxt;
      out_mirror_y     <= mirror_y_nxt;
      out_near_top_y   <= near_top_nxt;
      out_mirror_top_y <= mirror_top_nxt;
      out_last         <= stat.last_point;
    end
  end

endmodule

// ===== hdl/dda_mirrored_edge_rasterizer_unit.sv =====
// dda_mirrored_edge_rasterizer_unit: top level of the mirrored edge rasteriser
// depends on dmer_pkg, dmer_ctrl and dmer_dp
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------------------
//   in      | sink      | in_valid, in_ready, start/end x/y, origin x/y, lift
//   out     | source    | out_valid, out_ready, near/mirror x/y, near/mirror top y, last
//
// an item has an accept step, MAG_W+FRAC_BITS division steps (22 at the defaults,
// MAG_W = clog2(2*MAX_REACH+1)) and then steps+1 result points, steps = max(|dx|,|dy|)
// after the division, one point leaves per cycle while out_ready is high
// reset is synchronous and active low; it clears the sequencer and result valid
// out_ready low while a result waits holds the result register and pauses stepping;
// in_ready is high when idle, even while the last result of the previous item waits
module dda_mirrored_edge_rasterizer_unit import dmer_pkg::*; #(
  parameter int MAX_REACH = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  in_start_x,
  input  logic signed [COORD_W-1:0]  in_start_y,
  input  logic signed [COORD_W-1:0]  in_end_x,
  input  logic signed [COORD_W-1:0]  in_end_y,
  input  logic        [ORIGIN_W-1:0] in_origin_x,
  input  logic        [ORIGIN_W-1:0] in_origin_y,
  input  logic        [LIFT_W-1:0]   in_lift,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    out_near_x,
  output logic signed [OUT_W-1:0]    out_near_y,
  output logic signed [OUT_W-1:0]    out_mirror_x,
  output logic signed [OUT_W-1:0]    out_mirror_y,
  output logic signed [OUT_W-1:0]    out_near_top_y,
  output logic signed [OUT_W-1:0]    out_mirror_top_y,
  output logic                       out_last
);

  localparam int MAG_W   = $clog2(2 * MAX_REACH + 1);
  localparam int DIV_CYC = MAG_W + FRAC_BITS;

  dmer_cmd_t  cmd;
  dmer_stat_t stat;

  // sequencer
  dmer_ctrl #(
    .DIV_CYC (DIV_CYC)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and result register
  dmer_dp #(
    .MAX_REACH (MAX_REACH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_lift          (in_lift),
    .out_near_x       (out_near_x),
    .out_near_y       (out_near_y),
    .out_mirror_x     (out_mirror_x),
    .out_mirror_y     (out_mirror_y),
    .out_near_top_y   (out_near_top_y),
    .out_mirror_top_y (out_mirror_top_y),
    .out_last         (out_last)
  );

endmodule
